// File: sv/jtt_pkg.sv
// Shared types and constants for the journal transaction tracker.
// Used by every module of the block; depends on nothing.
package jtt_pkg;

    localparam int LOG_ENTRIES = 30;
    localparam int OP_BLOCKS   = 10;
    localparam int BLK_W       = 32;
    localparam int CNT_W       = 5;
    localparam int IDX_W       = (LOG_ENTRIES > 1) ? $clog2(LOG_ENTRIES) : 1;
    localparam int NEED_W      = 10;
    localparam int ADDR_W      = 3;

    // Register index, taken from paddr[2]
    localparam logic REG_START  = 1'b0;
    localparam logic REG_REGION = 1'b1;

    typedef enum logic [1:0] {
        CMD_BEGIN  = 2'd0,
        CMD_RECORD = 2'd1,
        CMD_END    = 2'd2
    } t_cmd;

    typedef enum logic [3:0] {
        ST_ADMITTED  = 4'd0,
        ST_WAIT      = 4'd1,
        ST_NEW       = 4'd2,
        ST_ABSORBED  = 4'd3,
        ST_FULL_ERR  = 4'd4,
        ST_OUT_ERR   = 4'd5,
        ST_RELEASED  = 4'd6,
        ST_COPY_LOG  = 4'd7,
        ST_HDR_WRITE = 4'd8,
        ST_INSTALL   = 4'd9,
        ST_HDR_CLEAR = 4'd10,
        ST_END_ERR   = 4'd11
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_EMIT,
        S_CP_RD,
        S_CP_OUT,
        S_HDR,
        S_IN_RD,
        S_IN_OUT,
        S_CLR
    } t_state;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic [BLK_W-1:0] wr_data;
        logic [BLK_W-1:0] key;
    } t_tbl_req;

    typedef struct packed {
        logic [BLK_W-1:0] start;
        logic [BLK_W-1:0] region;
    } t_cfg;

endpackage

// File: sv/jtt_cfg.sv
// APB register file: journal start block and journal region size.
// Depends on jtt_pkg.
module jtt_cfg
    import jtt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    logic [BLK_W-1:0] r_start;
    logic [BLK_W-1:0] r_region;
    logic             wr_req;

    assign pready = 1'b1;
    assign wr_req = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start  <= '0;
            r_region <= BLK_W'(31);
        end else if (wr_req) begin
            if (paddr[2] == REG_REGION) begin
                r_region <= pwdata;
            end else begin
                r_start <= pwdata;
            end
        end
    end

    assign prdata       = (paddr[2] == REG_START) ? r_start : r_region;
    assign o_cfg.start  = r_start;
    assign o_cfg.region = r_region;

endmodule

// File: sv/jtt_table.sv
// Logged-block table: one write port, one registered read port, and the
// key compare used by the record search. Depends on jtt_pkg.
module jtt_table
    import jtt_pkg::*;
(
    input  logic             i_clk,
    input  t_tbl_req         i_req,
    output logic [BLK_W-1:0] o_rd_data,
    output logic             o_hit
);

    logic [BLK_W-1:0] r_mem [LOG_ENTRIES];
    logic [BLK_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    // Hold read data until the next read request
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_hit     = (r_rd_data == i_req.key);

endmodule

// File: sv/jtt_ctrl.sv
// Sequencer of the journal tracker: command decode, table search, commit
// walk and the output register. Depends on jtt_pkg; drives jtt_table.
module jtt_ctrl
    import jtt_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [BLK_W-1:0] i_s_tdata,
    input  logic [1:0]       i_s_tuser,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [71:0]      o_m_tdata,
    output logic [3:0]       o_m_tuser,
    output logic             o_m_tlast,
    output t_tbl_req         o_tbl_req,
    input  logic [BLK_W-1:0] i_rd_data,
    input  logic             i_hit
);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_open, n_open;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0] r_n, n_n;
    logic [BLK_W-1:0] r_key, n_key;
    t_status          r_pend_st, n_pend_st;
    logic [CNT_W-1:0] r_pend_cnt, n_pend_cnt;

    logic             r_m_valid, n_m_valid;
    t_status          r_m_st, n_m_st;
    logic [BLK_W-1:0] r_m_src, n_m_src;
    logic [BLK_W-1:0] r_m_dst, n_m_dst;
    logic [CNT_W-1:0] r_m_cnt, n_m_cnt;
    logic             r_m_last, n_m_last;

    logic             s_accept;
    logic             slot_free;
    t_cmd             cmd;
    logic [NEED_W-1:0] need;
    logic             begin_over;
    logic             rec_full;
    logic             rec_outside;
    logic             end_commit;
    logic             srch_done;
    logic             walk_done;
    logic [BLK_W-1:0] slot_blk;

    logic             emit;
    t_status          e_st;
    logic [BLK_W-1:0] e_src;
    logic [BLK_W-1:0] e_dst;
    logic [CNT_W-1:0] e_cnt;
    logic             e_last;

    assign o_s_tready = (r_state == S_IDLE);
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign slot_free  = !r_m_valid || i_m_tready;
    assign cmd        = t_cmd'(i_s_tuser);

    assign need        = NEED_W'(r_count)
                       + (NEED_W'(r_open) + NEED_W'(1)) * NEED_W'(OP_BLOCKS);
    assign begin_over  = need > NEED_W'(LOG_ENTRIES);
    assign rec_full    = (r_count >= CNT_W'(LOG_ENTRIES))
                      || ((33'(r_count) + 33'd1) >= 33'(i_cfg.region));
    assign rec_outside = (r_open == '0);
    assign end_commit  = (r_open == CNT_W'(1)) && (r_count != '0);
    assign srch_done   = (r_idx + CNT_W'(1)) == r_count;
    assign walk_done   = (r_idx + CNT_W'(1)) == r_n;
    // Shared adder: log slot address for the current walk index
    assign slot_blk    = i_cfg.start + BLK_W'(r_idx) + BLK_W'(1);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    case (cmd)
                        CMD_BEGIN: n_state = S_EMIT;
                        CMD_RECORD: begin
                            if (rec_full || rec_outside || r_count == '0) begin
                                n_state = S_EMIT;
                            end else begin
                                n_state = S_SRCH_RD;
                            end
                        end
                        CMD_END: begin
                            if (!rec_outside && end_commit) begin
                                n_state = S_CP_RD;
                            end else begin
                                n_state = S_EMIT;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_SRCH_RD:  n_state = S_SRCH_CMP;
            S_SRCH_CMP: begin
                if (i_hit || srch_done) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_SRCH_RD;
                end
            end
            S_EMIT: begin
                if (slot_free) n_state = S_IDLE;
            end
            S_CP_RD:  n_state = S_CP_OUT;
            S_CP_OUT: begin
                if (slot_free) n_state = walk_done ? S_HDR : S_CP_RD;
            end
            S_HDR: begin
                if (slot_free) n_state = S_IN_RD;
            end
            S_IN_RD:  n_state = S_IN_OUT;
            S_IN_OUT: begin
                if (slot_free) n_state = walk_done ? S_CLR : S_IN_RD;
            end
            S_CLR: begin
                if (slot_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath actions and result requests
    always_comb begin
        n_count    = r_count;
        n_open     = r_open;
        n_idx      = r_idx;
        n_n        = r_n;
        n_key      = r_key;
        n_pend_st  = r_pend_st;
        n_pend_cnt = r_pend_cnt;

        o_tbl_req.rd_en   = 1'b0;
        o_tbl_req.rd_addr = r_idx[IDX_W-1:0];
        o_tbl_req.wr_en   = 1'b0;
        o_tbl_req.wr_addr = r_count[IDX_W-1:0];
        o_tbl_req.wr_data = r_key;
        o_tbl_req.key     = r_key;

        emit   = 1'b0;
        e_st   = r_pend_st;
        e_src  = '0;
        e_dst  = '0;
        e_cnt  = r_pend_cnt;
        e_last = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    n_pend_cnt = r_count;
                    n_idx      = '0;
                    n_key      = i_s_tdata;
                    case (cmd)
                        CMD_BEGIN: begin
                            if (begin_over) begin
                                n_pend_st = ST_WAIT;
                            end else begin
                                n_pend_st = ST_ADMITTED;
                                n_open    = r_open + CNT_W'(1);
                            end
                        end
                        CMD_RECORD: begin
                            if (rec_full) begin
                                n_pend_st = ST_FULL_ERR;
                            end else if (rec_outside) begin
                                n_pend_st = ST_OUT_ERR;
                            end else if (r_count == '0) begin
                                // Empty table: insert without a search
                                o_tbl_req.wr_en   = 1'b1;
                                o_tbl_req.wr_data = i_s_tdata;
                                n_count           = r_count + CNT_W'(1);
                                n_pend_st         = ST_NEW;
                                n_pend_cnt        = r_count + CNT_W'(1);
                            end
                        end
                        CMD_END: begin
                            if (rec_outside) begin
                                n_pend_st = ST_END_ERR;
                            end else begin
                                n_open    = r_open - CNT_W'(1);
                                n_pend_st = ST_RELEASED;
                                n_n       = r_count;
                            end
                        end
                        default: n_pend_st = r_pend_st;
                    endcase
                end
            end
            S_SRCH_RD: begin
                o_tbl_req.rd_en = 1'b1;
            end
            S_SRCH_CMP: begin
                if (i_hit) begin
                    n_pend_st  = ST_ABSORBED;
                    n_pend_cnt = r_count;
                end else if (srch_done) begin
                    o_tbl_req.wr_en = 1'b1;
                    n_count         = r_count + CNT_W'(1);
                    n_pend_st       = ST_NEW;
                    n_pend_cnt      = r_count + CNT_W'(1);
                end else begin
                    n_idx = r_idx + CNT_W'(1);
                end
            end
            S_EMIT: begin
                emit   = 1'b1;
                e_last = 1'b1;
            end
            S_CP_RD, S_IN_RD: begin
                o_tbl_req.rd_en = 1'b1;
            end
            S_CP_OUT: begin
                emit  = 1'b1;
                e_st  = ST_COPY_LOG;
                e_src = i_rd_data;
                e_dst = slot_blk;
                e_cnt = r_n;
                if (slot_free) n_idx = r_idx + CNT_W'(1);
            end
            S_HDR: begin
                emit  = 1'b1;
                e_st  = ST_HDR_WRITE;
                e_dst = i_cfg.start;
                e_cnt = r_n;
                if (slot_free) n_idx = '0;
            end
            S_IN_OUT: begin
                emit  = 1'b1;
                e_st  = ST_INSTALL;
                e_src = slot_blk;
                e_dst = i_rd_data;
                e_cnt = r_n;
                if (slot_free) n_idx = r_idx + CNT_W'(1);
            end
            S_CLR: begin
                emit   = 1'b1;
                e_st   = ST_HDR_CLEAR;
                e_dst  = i_cfg.start;
                e_cnt  = '0;
                e_last = 1'b1;
                if (slot_free) n_count = '0;
            end
            default: emit = 1'b0;
        endcase

        // Output register: load a new result or drop the one taken
        n_m_st   = r_m_st;
        n_m_src  = r_m_src;
        n_m_dst  = r_m_dst;
        n_m_cnt  = r_m_cnt;
        n_m_last = r_m_last;
        if (emit && slot_free) begin
            n_m_valid = 1'b1;
            n_m_st    = e_st;
            n_m_src   = e_src;
            n_m_dst   = e_dst;
            n_m_cnt   = e_cnt;
            n_m_last  = e_last;
        end else if (i_m_tready) begin
            n_m_valid = 1'b0;
        end else begin
            n_m_valid = r_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_open    <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_open    <= n_open;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_n        <= n_n;
        r_key      <= n_key;
        r_pend_st  <= n_pend_st;
        r_pend_cnt <= n_pend_cnt;
        r_m_st     <= n_m_st;
        r_m_src    <= n_m_src;
        r_m_dst    <= n_m_dst;
        r_m_cnt    <= n_m_cnt;
        r_m_last   <= n_m_last;
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tuser  = r_m_st;
    assign o_m_tdata  = {3'b000, r_m_cnt, r_m_dst, r_m_src};
    assign o_m_tlast  = r_m_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(LOG_ENTRIES))
        else $error("logged count beyond table size");

    a_commit_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CP_RD || r_state == S_CP_OUT || r_state == S_HDR ||
         r_state == S_IN_RD || r_state == S_IN_OUT || r_state == S_CLR)
        |-> (r_open == '0))
        else $error("commit running with an open operation");

    a_walk_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CP_RD || r_state == S_IN_RD) |-> (r_idx < r_n))
        else $error("commit walk index past committed count");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR && slot_free) |=> (r_count == '0 && r_state == S_IDLE))
        else $error("table not emptied after header clear");

endmodule

// File: sv/journal_transaction_tracker_top.sv
// Top level of the journal transaction tracker with group commit.
// Depends on jtt_pkg, jtt_cfg, jtt_table and jtt_ctrl.
//
// Usage:
//   Input stream: tuser carries the command (begin, record, end), tdata the
//   home block number. Output stream: tuser carries the status, tdata the
//   source block, destination block and header count; tlast marks the final
//   result of each request. Registers must be written over the APB port only
//   while the block is idle; the block itself does not enforce this.
//   Timing: one request at a time; o_s_tready is high only in the idle state.
//   Begin, non-committing end, rejected record and empty-table record requests
//   load their result from the emit state once the output register is free. A record
//   otherwise scans the table through the single read port and compare, a read
//   state then a compare state per entry, until a hit or the last entry.
//   A commit walks the table twice over the same read port and slot adder:
//   copy walk, header write, install walk, header clear. The next request
//   is taken the cycle after the last result enters the output register.
//   Reset empties the table and the open count and restores the register
//   defaults. A stalled receiver holds the output register, and the walk
//   waits in place until the register frees.
module journal_transaction_tracker_top
    import jtt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [31:0]       i_s_tdata,   // [31:0] block_number
    input  logic [1:0]        i_s_tuser,   // [1:0] command
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [71:0]       o_m_tdata,   // [31:0] source_block, [63:32] dest_block,
                                           // [68:64] header_count, [71:69] zero
    output logic [3:0]        o_m_tuser,   // [3:0] status
    output logic              o_m_tlast,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    t_cfg             cfg;
    t_tbl_req         tbl_req;
    logic [BLK_W-1:0] tbl_rd_data;
    logic             tbl_hit;

    jtt_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    jtt_table u_table (
        .i_clk     (i_clk),
        .i_req     (tbl_req),
        .o_rd_data (tbl_rd_data),
        .o_hit     (tbl_hit)
    );

    jtt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast),
        .o_tbl_req  (tbl_req),
        .i_rd_data  (tbl_rd_data),
        .i_hit      (tbl_hit)
    );

endmodule
